// File: rtl/assert_macros.svh
// Assertion shorthands shared by the tile enumerator RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define VTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in this cycle implies property in the next cycle.
`define VTE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/vte_pkg.sv
// Package for the visible tile enumerator: constants, word types, job descriptor.
// No dependencies; every RTL module file imports it.
package vte_pkg;

  localparam int TILE_PIXELS = 256;
  localparam int MAX_TILES   = 64;
  localparam int FRAC_BITS   = 8;

  localparam int EXTENT_W   = 12;
  localparam int CTR_W      = 36;
  localparam int ROT_W      = 16;
  localparam int ZOOM_W     = 5;
  localparam int MARGIN_W   = 10;
  localparam int LIMIT_W    = $clog2(MAX_TILES + 1);
  localparam int COORD_W    = 19;
  localparam int CFG_DATA_W = CTR_W;

  localparam int ZOOM_MAX = 19;
  localparam int DZ_MIN   = 2;

  // common world scale is 2^-(FRAC_BITS + CTR_SHIFT) pixels
  localparam int CTR_SHIFT  = 15;
  localparam int BASE_SHIFT = $clog2(TILE_PIXELS) + FRAC_BITS + CTR_SHIFT;
  localparam int HALF_W     = EXTENT_W + 1;
  localparam int PROD_W     = HALF_W + ROT_W + 1;
  localparam int EXT_W      = PROD_W;
  localparam int WORLD_W    = CTR_W + CTR_SHIFT + 3;
  localparam int SHIFT_MIN  = BASE_SHIFT + DZ_MIN - ZOOM_MAX;
  localparam int TIDX_W     = WORLD_W - SHIFT_MIN;
  localparam int SHAMT_W    = $clog2(BASE_SHIFT + ZOOM_MAX + 1);

  // job queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [EXTENT_W-1:0] RST_SCREEN_W  = EXTENT_W'(320);
  localparam logic [EXTENT_W-1:0] RST_SCREEN_H  = EXTENT_W'(240);
  localparam logic [ROT_W-1:0]    RST_ROT_COS   = ROT_W'(16384);
  localparam logic [ROT_W-1:0]    RST_ROT_SIN   = ROT_W'(0);
  localparam logic [ZOOM_W-1:0]   RST_DISP_ZOOM = ZOOM_W'(16);
  localparam logic [ZOOM_W-1:0]   RST_DATA_ZOOM = ZOOM_W'(14);

  typedef enum logic [2:0] {
    CFG_SCREEN_W,
    CFG_SCREEN_H,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_ROT_COS,
    CFG_ROT_SIN,
    CFG_DISP_ZOOM,
    CFG_DATA_ZOOM
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUM,
    FR_ADD,
    FR_SHIFT,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic [LIMIT_W-1:0]  tile_limit;
  } in_word_t;

  typedef struct packed {
    logic [ZOOM_W-1:0]  tile_zoom;
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [ZOOM_W-1:0]        tz;
    logic [COORD_W-1:0]       col_mask;
    logic signed [TIDX_W-1:0] tx0;
    logic signed [TIDX_W-1:0] tx1;
    logic [COORD_W-1:0]       ty0;
    logic [COORD_W-1:0]       ty1;
    logic [LIMIT_W-1:0]       limit;
  } tile_job_t;

endpackage

// File: rtl/vte_queue.sv
// Short job queue between the request front end and the tile back end.
// Depends on vte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vte_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  vte_pkg::tile_job_t push_job,
  output logic               pop_valid,
  input  logic               pop_ready,
  output vte_pkg::tile_job_t pop_job
);
  import vte_pkg::*;

  tile_job_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `VTE_ASSERT(a_q_count_bound, count_r <= (QPTR_W + 1)'(QDEPTH), "queue count overflow")
  `VTE_ASSERT_NEXT(a_q_pop_drains, do_pop && !do_push, count_r == $past(count_r) - 1'b1, "pop lost")

endmodule

// File: rtl/vte_front.sv
// Front end: configuration registers, request intake, corner rotation and
// tile range computation; pushes one job per non-empty request. Uses vte_pkg.
`include "assert_macros.svh"

module vte_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  vte_pkg::cfg_idx_t               cfg_addr,
  input  logic [vte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vte_pkg::in_word_t               in_data,
  output logic                            job_valid,
  input  logic                            job_ready,
  output vte_pkg::tile_job_t              job
);
  import vte_pkg::*;

  // configuration
  logic [EXTENT_W-1:0]     scr_w_r, scr_h_r;
  logic [CTR_W-1:0]        ctr_x_r, ctr_y_r;
  logic signed [ROT_W-1:0] cos_r, sin_r;
  logic [ZOOM_W-1:0]       dzoom_r, tzoom_r;

  front_state_t state_r, state_nxt;

  logic [MARGIN_W-1:0]        margin_r;
  logic [LIMIT_W-1:0]         limit_r;
  logic signed [PROD_W-1:0]   prod_a_r, prod_b_r, prod_c_r, prod_d_r;
  logic [EXT_W-1:0]           ext_x_r, ext_y_r;
  logic signed [WORLD_W-1:0]  wmin_x_r, wmax_x_r, wmin_y_r, wmax_y_r;
  logic signed [TIDX_W-1:0]   tx0_r, tx1_r, ty0_r, ty1_r;

  logic [ZOOM_W-1:0]          dz, tz;
  logic [SHAMT_W-1:0]         shamt;
  logic [LIMIT_W-1:0]         lim_sat;
  logic [HALF_W-1:0]          half_w, half_h;
  logic [PROD_W-1:0]          abs_a, abs_b, abs_c, abs_d;
  logic signed [WORLD_W-1:0]  cxs, cys, off_x, off_y;
  logic [COORD_W-1:0]         col_mask;
  logic signed [TIDX_W-1:0]   row_top, ty0_c, ty1_c;
  logic                       rows_empty;
  logic                       in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RST_SCREEN_W;
      scr_h_r <= RST_SCREEN_H;
      ctr_x_r <= '0;
      ctr_y_r <= '0;
      cos_r   <= RST_ROT_COS;
      sin_r   <= RST_ROT_SIN;
      dzoom_r <= RST_DISP_ZOOM;
      tzoom_r <= RST_DATA_ZOOM;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCREEN_W:  scr_w_r <= cfg_wdata[EXTENT_W-1:0];
        CFG_SCREEN_H:  scr_h_r <= cfg_wdata[EXTENT_W-1:0];
        CFG_CENTER_X:  ctr_x_r <= cfg_wdata[CTR_W-1:0];
        CFG_CENTER_Y:  ctr_y_r <= cfg_wdata[CTR_W-1:0];
        CFG_ROT_COS:   cos_r   <= cfg_wdata[ROT_W-1:0];
        CFG_ROT_SIN:   sin_r   <= cfg_wdata[ROT_W-1:0];
        CFG_DISP_ZOOM: dzoom_r <= cfg_wdata[ZOOM_W-1:0];
        CFG_DATA_ZOOM: tzoom_r <= cfg_wdata[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // zoom saturation and the combined tile shift
  assign dz = (dzoom_r < ZOOM_W'(DZ_MIN))   ? ZOOM_W'(DZ_MIN)   :
              (dzoom_r > ZOOM_W'(ZOOM_MAX)) ? ZOOM_W'(ZOOM_MAX) : dzoom_r;
  assign tz = (tzoom_r > ZOOM_W'(ZOOM_MAX)) ? ZOOM_W'(ZOOM_MAX) : tzoom_r;
  assign shamt = SHAMT_W'(BASE_SHIFT) + SHAMT_W'(dz) - SHAMT_W'(tz);

  assign lim_sat = (in_data.tile_limit > LIMIT_W'(MAX_TILES)) ? LIMIT_W'(MAX_TILES)
                                                              : in_data.tile_limit;
  assign in_take = in_valid && in_ready;

  // half extents in half-pixel units
  assign half_w = HALF_W'(scr_w_r) + HALF_W'({margin_r, 1'b0});
  assign half_h = HALF_W'(scr_h_r) + HALF_W'({margin_r, 1'b0});

  assign abs_a = prod_a_r[PROD_W-1] ? PROD_W'(-prod_a_r) : prod_a_r;
  assign abs_b = prod_b_r[PROD_W-1] ? PROD_W'(-prod_b_r) : prod_b_r;
  assign abs_c = prod_c_r[PROD_W-1] ? PROD_W'(-prod_c_r) : prod_c_r;
  assign abs_d = prod_d_r[PROD_W-1] ? PROD_W'(-prod_d_r) : prod_d_r;

  assign cxs   = {{(WORLD_W - CTR_W - CTR_SHIFT){1'b0}}, ctr_x_r, {CTR_SHIFT{1'b0}}};
  assign cys   = {{(WORLD_W - CTR_W - CTR_SHIFT){1'b0}}, ctr_y_r, {CTR_SHIFT{1'b0}}};
  assign off_x = WORLD_W'({ext_x_r, {FRAC_BITS{1'b0}}});
  assign off_y = WORLD_W'({ext_y_r, {FRAC_BITS{1'b0}}});

  // row clamp to the map
  assign col_mask   = COORD_W'(({{COORD_W{1'b0}}, 1'b1} << tz) - 1'b1);
  assign row_top    = TIDX_W'(col_mask);
  assign ty0_c      = ty0_r[TIDX_W-1] ? '0 : ty0_r;
  assign ty1_c      = (ty1_r > row_top) ? row_top : ty1_r;
  assign rows_empty = (ty0_c > ty1_c);

  assign job.tz       = tz;
  assign job.col_mask = col_mask;
  assign job.tx0      = tx0_r;
  assign job.tx1      = tx1_r;
  assign job.ty0      = ty0_c[COORD_W-1:0];
  assign job.ty1      = ty1_c[COORD_W-1:0];
  assign job.limit    = limit_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE:  if (in_take && lim_sat != '0) state_nxt = FR_MUL;
      FR_MUL:   state_nxt = FR_SUM;
      FR_SUM:   state_nxt = FR_ADD;
      FR_ADD:   state_nxt = FR_SHIFT;
      FR_SHIFT: state_nxt = FR_PUSH;
      FR_PUSH:  if (rows_empty || job_ready) state_nxt = FR_IDLE;
      default:  state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_valid = 1'b0;
    unique case (state_r)
      FR_IDLE: in_ready  = 1'b1;
      FR_PUSH: job_valid = !rows_empty;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      margin_r <= in_data.margin;
      limit_r  <= lim_sat;
    end
    if (state_r == FR_MUL) begin
      prod_a_r <= PROD_W'($signed({1'b0, half_w}) * cos_r);
      prod_b_r <= PROD_W'($signed({1'b0, half_h}) * sin_r);
      prod_c_r <= PROD_W'($signed({1'b0, half_w}) * sin_r);
      prod_d_r <= PROD_W'($signed({1'b0, half_h}) * cos_r);
    end
    // corner extremes: +-(|a|+|b|) covers all four corners
    if (state_r == FR_SUM) begin
      ext_x_r <= abs_a + abs_b;
      ext_y_r <= abs_c + abs_d;
    end
    if (state_r == FR_ADD) begin
      wmin_x_r <= cxs - off_x;
      wmax_x_r <= cxs + off_x;
      wmin_y_r <= cys - off_y;
      wmax_y_r <= cys + off_y;
    end
    // flooring divide by a power of two
    if (state_r == FR_SHIFT) begin
      tx0_r <= TIDX_W'(wmin_x_r >>> shamt);
      tx1_r <= TIDX_W'(wmax_x_r >>> shamt);
      ty0_r <= TIDX_W'(wmin_y_r >>> shamt);
      ty1_r <= TIDX_W'(wmax_y_r >>> shamt);
    end
  end

  `VTE_ASSERT(a_fr_job_rows, !job_valid || ((job.ty0 <= job.ty1) && (job.ty1 <= job.col_mask)), "bad job rows")
  `VTE_ASSERT(a_fr_job_limit, !job_valid || ((job.limit != '0) && (job.limit <= LIMIT_W'(MAX_TILES))), "bad job limit")

endmodule

// File: rtl/vte_back.sv
// Back end: walks one job's tile rectangle row by row into an output register.
// Depends on vte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  vte_pkg::tile_job_t job,
  output logic               out_valid,
  input  logic               out_ready,
  output vte_pkg::out_word_t out_data
);
  import vte_pkg::*;

  back_state_t              state_r, state_nxt;
  tile_job_t                job_r;
  logic signed [TIDX_W-1:0] tx_r;
  logic [COORD_W-1:0]       ty_r;
  logic [LIMIT_W-1:0]       cnt_r;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_data_r;

  logic emit, col_end, row_end, tile_last, job_take;

  assign job_take  = job_valid && job_ready;
  assign emit      = (state_r == BK_RUN) && (!out_valid_r || out_ready);
  assign col_end   = (tx_r == job_r.tx1);
  assign row_end   = (ty_r == job_r.ty1);
  assign tile_last = (LIMIT_W'(cnt_r + 1'b1) == job_r.limit) || (col_end && row_end);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) state_nxt = BK_RUN;
      BK_RUN:  if (emit && tile_last) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    unique case (state_r)
      BK_IDLE: job_ready = 1'b1;
      default: ;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (job_take) begin
        cnt_r <= '0;
      end else if (emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job;
      tx_r  <= job.tx0;
      ty_r  <= job.ty0;
    end else if (emit) begin
      if (col_end) begin
        tx_r <= job_r.tx0;
        ty_r <= ty_r + 1'b1;
      end else begin
        tx_r <= tx_r + 1'b1;
      end
    end
    if (emit) begin
      out_data_r.tile_zoom <= job_r.tz;
      out_data_r.tile_col  <= tx_r[COORD_W-1:0] & job_r.col_mask;
      out_data_r.tile_row  <= ty_r;
      out_data_r.last      <= tile_last;
    end
  end

  `VTE_ASSERT_NEXT(a_bk_last_ends, emit && tile_last, state_r == BK_IDLE, "job did not end on last")
  `VTE_ASSERT(a_bk_cnt_bound, (state_r != BK_RUN) || (cnt_r < job_r.limit), "tile count past limit")

endmodule

// File: rtl/visible_tile_enumerator_top.sv
// Top level of the visible tile enumerator: front end, job queue, back end.
// Depends on vte_pkg, vte_front, vte_queue and vte_back.

// A request (margin, tile_limit) is taken when the front end is free; the
// front end takes it through intake, multiply, extent sum, centre add,
// tile shift and queue push before it takes the next request. Requests
// with a zero limit or no rows on the map produce no words. The back end
// takes a job while idle and then emits one tile word per cycle from a
// registered output while out_ready allows, until the job's last tile.
// A two-entry job queue lets the front end work ahead while tiles drain.
// Configuration writes take effect at once and belong in idle periods.
module visible_tile_enumerator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  vte_pkg::cfg_idx_t              cfg_addr,
  input  logic [vte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vte_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vte_pkg::out_word_t             out_data
);
  import vte_pkg::*;

  logic      fq_valid, fq_ready;
  tile_job_t fq_job;
  logic      qb_valid, qb_ready;
  tile_job_t qb_job;

  vte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  vte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  vte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/testbench.sv
// Testbench for visible_tile_enumerator_top: directed and random tile requests under
// random back-pressure, checked word by word against a tile prediction scoreboard.
// Depends on vte_pkg and the enumerator RTL; no files or arguments are read.
module testbench;
  import vte_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 32;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 22;
  localparam int WORLD_SHIFT = $clog2(TILE_PIXELS) + FRAC_BITS;

  class tile_scoreboard;
    logic [EXTENT_W-1:0] scr_w, scr_h;
    logic [CTR_W-1:0]    ctr_x, ctr_y;
    shortint             rot_c, rot_s;
    logic [ZOOM_W-1:0]   zoom_disp, zoom_data;
    out_word_t           tiles[$];
    int                  fail_count;

    function new();
      scr_w = RST_SCREEN_W;
      scr_h = RST_SCREEN_H;
      ctr_x = '0;
      ctr_y = '0;
      rot_c = RST_ROT_COS;
      rot_s = RST_ROT_SIN;
      zoom_disp = RST_DISP_ZOOM;
      zoom_data = RST_DATA_ZOOM;
      fail_count = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SCREEN_W:  scr_w = val[EXTENT_W-1:0];
        CFG_SCREEN_H:  scr_h = val[EXTENT_W-1:0];
        CFG_CENTER_X:  ctr_x = val[CTR_W-1:0];
        CFG_CENTER_Y:  ctr_y = val[CTR_W-1:0];
        CFG_ROT_COS:   rot_c = val[ROT_W-1:0];
        CFG_ROT_SIN:   rot_s = val[ROT_W-1:0];
        CFG_DISP_ZOOM: zoom_disp = val[ZOOM_W-1:0];
        CFG_DATA_ZOOM: zoom_data = val[ZOOM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return tiles.size();
    endfunction

    function longint floor_quot(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    // floor(w * 2^up / div), kept exact without widening w
    function longint tile_floor(longint w, longint div, int up);
      longint q, r;
      q = floor_quot(w, div);
      r = w - q * div;
      return (q <<< up) + ((r <<< up) / div);
    endfunction

    function void note_request(in_word_t w);
      longint lim, hw, hh, cxs, cys, cs, sn, dx, dy, wx, wy;
      longint minx, maxx, miny, maxy, base, d, tx0, tx1, ty0, ty1, n, ty, tx, col;
      int dz, tz, cnt;
      bit held_ok;
      out_word_t held;
      lim = (w.tile_limit > MAX_TILES) ? MAX_TILES : w.tile_limit;
      if (lim == 0) return;
      dz = zoom_disp;
      if (dz < DZ_MIN) dz = DZ_MIN;
      if (dz > ZOOM_MAX) dz = ZOOM_MAX;
      tz = zoom_data;
      if (tz > ZOOM_MAX) tz = ZOOM_MAX;
      cs = rot_c;
      sn = rot_s;
      // half extents held in half-pixel units
      hw = longint'(scr_w) + 2 * longint'(w.margin);
      hh = longint'(scr_h) + 2 * longint'(w.margin);
      cxs = longint'(ctr_x) <<< CTR_SHIFT;
      cys = longint'(ctr_y) <<< CTR_SHIFT;
      for (int i = 0; i < 4; i++) begin
        dx = (i == 1 || i == 2) ? hw : -hw;
        dy = (i >= 2) ? hh : -hh;
        wx = cxs + ((dx * cs - dy * sn) <<< FRAC_BITS);
        wy = cys + ((dx * sn + dy * cs) <<< FRAC_BITS);
        if (i == 0 || wx < minx) minx = wx;
        if (i == 0 || wx > maxx) maxx = wx;
        if (i == 0 || wy < miny) miny = wy;
        if (i == 0 || wy > maxy) maxy = wy;
      end
      base = longint'(TILE_PIXELS) <<< (FRAC_BITS + CTR_SHIFT);
      if (tz >= dz) begin
        tx0 = tile_floor(minx, base, tz - dz);
        tx1 = tile_floor(maxx, base, tz - dz);
        ty0 = tile_floor(miny, base, tz - dz);
        ty1 = tile_floor(maxy, base, tz - dz);
      end else begin
        d = base <<< (dz - tz);
        tx0 = floor_quot(minx, d);
        tx1 = floor_quot(maxx, d);
        ty0 = floor_quot(miny, d);
        ty1 = floor_quot(maxy, d);
      end
      n = longint'(1) <<< tz;
      if (ty0 < 0) ty0 = 0;
      if (ty1 > n - 1) ty1 = n - 1;
      held_ok = 1'b0;
      cnt = 0;
      for (ty = ty0; ty <= ty1 && cnt < lim; ty++) begin
        for (tx = tx0; tx <= tx1 && cnt < lim; tx++) begin
          col = tx % n;
          if (col < 0) col += n;
          if (held_ok) tiles.push_back(held);
          held.tile_zoom = ZOOM_W'(tz);
          held.tile_col  = COORD_W'(col);
          held.tile_row  = COORD_W'(ty);
          held.last      = 1'b0;
          held_ok = 1'b1;
          cnt++;
        end
      end
      if (held_ok) begin
        held.last = 1'b1;
        tiles.push_back(held);
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 100) $display("ERROR: %s", msg);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (tiles.size() == 0) begin
        report($sformatf("unexpected tile word zoom %0d col %0d row %0d last %0d",
                         got.tile_zoom, got.tile_col, got.tile_row, got.last));
        return;
      end
      want = tiles.pop_front();
      if (got.tile_zoom !== want.tile_zoom)
        report($sformatf("tile_zoom %0d, expected %0d", got.tile_zoom, want.tile_zoom));
      if (got.tile_col !== want.tile_col)
        report($sformatf("tile_col %0d, expected %0d", got.tile_col, want.tile_col));
      if (got.tile_row !== want.tile_row)
        report($sformatf("tile_row %0d, expected %0d", got.tile_row, want.tile_row));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d (col %0d row %0d)",
                         got.last, want.last, want.tile_col, want.tile_row));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_addr = CFG_SCREEN_W;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;

  bit             pressure_on = 1'b0;
  bit             hold_done;
  int             hold_left, rx_stall, rx_calm, tx_calm, quiet;
  tile_scoreboard sb;

  visible_tile_enumerator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : rx_side
    int g;
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (pressure_on && !hold_done) begin
      // one long hold-off so the queue fills and in_ready drops
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      g = pick_gap(rx_calm);
      out_ready <= (g == 0);
      rx_stall = (g > 0) ? g - 1 : 0;
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(w);
  endtask

  task automatic send_req(input logic [MARGIN_W-1:0] margin, input logic [LIMIT_W-1:0] lim);
    in_word_t w;
    w.margin = margin;
    w.tile_limit = lim;
    send_word(w);
  endtask

  // zero-tile requests leave no trace, so give the pipeline time to drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_setup(input logic [EXTENT_W-1:0] sw, input logic [EXTENT_W-1:0] sh,
                             input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy,
                             input logic [ROT_W-1:0] cs, input logic [ROT_W-1:0] sn,
                             input logic [ZOOM_W-1:0] dz, input logic [ZOOM_W-1:0] tz);
    settle_idle();
    write_reg(CFG_SCREEN_W, CFG_DATA_W'(sw));
    write_reg(CFG_SCREEN_H, CFG_DATA_W'(sh));
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_ROT_COS, CFG_DATA_W'(cs));
    write_reg(CFG_ROT_SIN, CFG_DATA_W'(sn));
    write_reg(CFG_DISP_ZOOM, CFG_DATA_W'(dz));
    write_reg(CFG_DATA_ZOOM, CFG_DATA_W'(tz));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [EXTENT_W-1:0] pick_extent();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'hFFF;
    if (r == 1) return 12'd1;
    if (r < 6) return EXTENT_W'($urandom_range(0, 4095));
    return EXTENT_W'($urandom_range(100, 1200));
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.margin = (r < 50) ? MARGIN_W'($urandom_range(0, 1023)) : MARGIN_W'($urandom_range(0, 48));
    r = $urandom_range(0, 99);
    if (r < 8) w.tile_limit = '0;
    else if (r < 18) w.tile_limit = LIMIT_W'($urandom_range(MAX_TILES + 1, 127));
    else w.tile_limit = LIMIT_W'($urandom_range(1, MAX_TILES));
    return w;
  endfunction

  task automatic random_setup();
    logic [63:0]         raw;
    logic [CTR_W-1:0]    cx, cy;
    logic [ROT_W-1:0]    cs, sn;
    logic [EXTENT_W-1:0] sw, sh;
    int                  dz, dzc, tz;
    real                 ang;
    sw = pick_extent();
    sh = pick_extent();
    dz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(DZ_MIN, ZOOM_MAX);
    dzc = (dz < DZ_MIN) ? DZ_MIN : (dz > ZOOM_MAX) ? ZOOM_MAX : dz;
    if ($urandom_range(0, 9) == 0) begin
      tz = $urandom_range(0, 31);
    end else begin
      tz = dzc + int'($urandom_range(0, 6)) - 3;
      if (tz < 0) tz = 0;
      if (tz > ZOOM_MAX) tz = ZOOM_MAX;
    end
    raw = {$urandom, $urandom};
    cx = raw[CTR_W-1:0];
    raw = {$urandom, $urandom};
    cy = raw[CTR_W-1:0];
    // mostly keep the centre on the map
    if ($urandom_range(0, 9) != 0) begin
      cx &= (36'd1 << (WORLD_SHIFT + dzc)) - 36'd1;
      cy &= (36'd1 << (WORLD_SHIFT + dzc)) - 36'd1;
    end
    if ($urandom_range(0, 6) == 0) begin
      cs = ROT_W'($urandom);
      sn = ROT_W'($urandom);
    end else begin
      ang = $urandom_range(0, 3599) * 3.141592653589793 / 1800.0;
      cs = ROT_W'($rtoi(16384.0 * $cos(ang)));
      sn = ROT_W'($rtoi(16384.0 * $sin(ang)));
    end
    apply_setup(sw, sh, cx, cy, cs, sn, ZOOM_W'(dz), ZOOM_W'(tz));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: view at the origin, upper rows clipped, left columns wrap
    send_req(10'd0, 7'd1);
    send_req(10'd0, 7'd0);
    send_req(10'd1023, 7'd127);
    send_req(10'd5, 7'd65);
    send_req(10'd512, 7'd64);

    // zooms past both ends, rotation beyond unit length, odd screen sizes
    apply_setup(12'hFFF, 12'd1, 36'hF_FFFF_FFFF, 36'h0_0002_0000,
                16'h8000, 16'h7FFF, 5'd0, 5'd31);
    send_req(10'd1023, 7'd64);
    send_req(10'd0, 7'd3);
    send_req(10'd341, 7'd64);
    send_req(10'd682, 7'd33);

    // centre far below the map: no rows left
    apply_setup(12'd1, 12'hFFF, 36'd0, 36'hF_FFFF_FFFF, 16'h4000, 16'h0000, 5'd31, 5'd0);
    send_req(10'd0, 7'd64);
    send_req(10'd1023, 7'd64);

    apply_setup(12'd320, 12'd240, 36'h4_0000_0000, 36'h4_0000_0000,
                16'd11585, 16'd11585, 5'd19, 5'd19);
    send_req(10'd100, 7'd64);
    send_req(10'd0, 7'd10);
    send_req(10'd3, 7'd1);

    apply_setup(12'd640, 12'd480, 36'd0, 36'd0, 16'hC000, 16'h0000, 5'd1, 5'd20);
    send_req(10'd7, 7'd20);
    send_req(10'd1023, 7'd64);

    for (int p = 0; p < PHASES; p++) begin
      random_setup();
      if (p == 0) pressure_on <= 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) send_word(random_request());
    end

    settle_idle();
    if (sb.fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
